// File: hdl/vgd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vgd_pkg
// Shared types and constants of the voxel grid downsampler.
// ----------------------------------------------------------------------------
package vgd_pkg;

    localparam int MaxPoints = 1024;
    localparam int PtIdxW    = 10;
    localparam int PtCntW    = 11;
    localparam int MaxCells  = 64;
    localparam int CellIdxW  = 6;
    localparam int CellCntW  = 7;
    localparam int CoordW    = 16;
    localparam int LevelW    = 5;
    localparam int MaxLevel  = 16;
    localparam int IdxW      = 16;
    localparam int RemW      = 17;
    localparam int ProdW     = 33;
    localparam int DiffW     = 35;
    localparam int SqW       = 32;
    localparam int ScoreW    = 34;
    localparam int CfgIdxW   = 2;
    localparam int CfgDataW  = 5;

    localparam logic [LevelW-1:0]  LevelReset     = 5'd6;
    localparam logic [CfgIdxW-1:0] CFG_KEEP_MODE  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_GRID_LEVEL = 2'd1;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic signed [CoordW-1:0] point_z;
        logic                     last_point;
    } t_point_in;

    typedef struct packed {
        logic [PtIdxW-1:0] kept_index;
        logic              final_result;
        logic              points_dropped;
        logic              voxels_dropped;
    } t_result_out;

    typedef struct packed {
        logic [3*IdxW-1:0] coords;
        logic [PtIdxW-1:0] kept;
        logic [ScoreW-1:0] best;
    } t_cell;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PT_RD,
        ST_DIV_INIT,
        ST_DIV,
        ST_MUL,
        ST_ABS,
        ST_SQ,
        ST_SUM,
        ST_CELL_RD,
        ST_CELL_CMP,
        ST_APPEND,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_OUT,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic                load_pt;
        logic                set_pdrop;
        logic                pt_rd;
        logic [PtIdxW-1:0]   pt_addr;
        logic                div_init;
        logic                div_step;
        logic                mul;
        logic                absd;
        logic                sq;
        logic                sum;
        logic                cell_rd;
        logic [CellIdxW-1:0] cell_addr;
        logic                cell_new;
        logic                cell_upd;
        logic                set_vdrop;
        logic                out_load;
        logic                out_final;
        logic                clear;
        logic [LevelW-1:0]   level;
    } t_dp_cmd;

    typedef struct packed {
        logic match;
        logic better;
        logic out_taken;
    } t_dp_status;

endpackage
`default_nettype wire

// File: hdl/vgd_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vgd_dpath
// Point store, bounding box, cell index divider, distance pipeline, cell
// table and output register.
// ----------------------------------------------------------------------------
module vgd_dpath import vgd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_point_in   i_point,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_status       o_status,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_result_out      o_out_data
);

    logic [3*CoordW-1:0] pt_mem [0:MaxPoints-1];
    logic [3*CoordW-1:0] r_pt_rd;
    t_cell               cell_mem [0:MaxCells-1];
    t_cell               r_cell;

    logic signed [CoordW-1:0] r_min [3];
    logic signed [CoordW-1:0] r_max [3];
    logic signed [CoordW-1:0] in_c  [3];

    logic [CoordW-1:0] r_off  [3];
    logic [CoordW-1:0] r_rng  [3];
    logic [RemW-1:0]   r_rem  [3];
    logic [IdxW-1:0]   r_q    [3];
    logic [IdxW-1:0]   r_idx  [3];
    logic [ProdW-1:0]  r_prod [3];
    logic [CoordW-1:0] r_ad   [3];
    logic [SqW-1:0]    r_sq   [3];
    logic [ScoreW-1:0] r_score;

    logic [CoordW-1:0] off_c  [3];
    logic [CoordW-1:0] rng_c  [3];
    logic [RemW-1:0]   rem2   [3];
    logic [IdxW-1:0]   idx_c  [3];
    logic signed [DiffW-1:0] diff [3];
    logic [DiffW-1:0]  mag    [3];
    logic [IdxW-1:0]   gmask;

    logic        r_pdrop, r_vdrop;
    logic        r_out_valid;
    t_result_out r_out;

    assign in_c[0] = i_point.point_x;
    assign in_c[1] = i_point.point_y;
    assign in_c[2] = i_point.point_z;
    assign gmask   = IdxW'((RemW'(1) << i_cmd.level) - RemW'(1));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            off_c[k] = r_pt_rd[k*CoordW +: CoordW] - r_min[k];
            rng_c[k] = r_max[k] - r_min[k];
            rem2[k]  = {r_rem[k][RemW-2:0], 1'b0};
            if (r_rng[k] == '0) begin
                idx_c[k] = '0;
            end else if (r_off[k] == r_rng[k]) begin
                idx_c[k] = gmask;
            end else begin
                idx_c[k] = r_q[k];
            end
            diff[k] = signed'(DiffW'(r_off[k]) << (i_cmd.level + 5'd1))
                    - signed'(DiffW'(r_prod[k]));
            mag[k]  = diff[k][DiffW-1] ? DiffW'(-diff[k]) : DiffW'(diff[k]);
        end
    end

    // point store
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pt) begin
            pt_mem[i_cmd.pt_addr] <= {i_point.point_z, i_point.point_y, i_point.point_x};
        end
        if (i_cmd.pt_rd) begin
            r_pt_rd <= pt_mem[i_cmd.pt_addr];
        end
    end

    // bounding box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int k = 0; k < 3; k++) begin
                r_min[k] <= {1'b0, {(CoordW-1){1'b1}}};
                r_max[k] <= {1'b1, {(CoordW-1){1'b0}}};
            end
        end else if (i_cmd.load_pt) begin
            for (int k = 0; k < 3; k++) begin
                if (in_c[k] < r_min[k]) r_min[k] <= in_c[k];
                if (in_c[k] > r_max[k]) r_max[k] <= in_c[k];
            end
        end
    end

    // divider and distance pipeline
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.div_init) begin
                r_off[k] <= off_c[k];
                r_rng[k] <= rng_c[k];
                r_rem[k] <= RemW'(off_c[k]);
                r_q[k]   <= '0;
            end else if (i_cmd.div_step) begin
                if (rem2[k] >= RemW'(r_rng[k])) begin
                    r_rem[k] <= rem2[k] - RemW'(r_rng[k]);
                    r_q[k]   <= {r_q[k][IdxW-2:0], 1'b1};
                end else begin
                    r_rem[k] <= rem2[k];
                    r_q[k]   <= {r_q[k][IdxW-2:0], 1'b0};
                end
            end
            if (i_cmd.mul) begin
                r_idx[k]  <= idx_c[k];
                r_prod[k] <= ProdW'({idx_c[k], 1'b1}) * ProdW'(r_rng[k]);
            end
            if (i_cmd.absd) begin
                r_ad[k] <= mag[k][CoordW-1:0];
            end
            if (i_cmd.sq) begin
                r_sq[k] <= SqW'(r_ad[k]) * SqW'(r_ad[k]);
            end
        end
        if (i_cmd.sum) begin
            r_score <= ScoreW'(r_sq[0]) + ScoreW'(r_sq[1]) + ScoreW'(r_sq[2]);
        end
    end

    // cell table
    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_new || i_cmd.cell_upd) begin
            cell_mem[i_cmd.cell_addr] <= '{coords: {r_idx[2], r_idx[1], r_idx[0]},
                                           kept: i_cmd.pt_addr, best: r_score};
        end
        if (i_cmd.cell_rd) begin
            r_cell <= cell_mem[i_cmd.cell_addr];
        end
    end

    // drop flags and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_pdrop <= 1'b0;
            r_vdrop <= 1'b0;
        end else begin
            if (i_cmd.set_pdrop) r_pdrop <= 1'b1;
            if (i_cmd.set_vdrop) r_vdrop <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= '{kept_index: r_cell.kept, final_result: i_cmd.out_final,
                       points_dropped: r_pdrop, voxels_dropped: r_vdrop};
        end
    end

    assign o_status.match     = (r_cell.coords == {r_idx[2], r_idx[1], r_idx[0]});
    assign o_status.better    = (r_score < r_cell.best);
    assign o_status.out_taken = r_out_valid && i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

endmodule
`default_nettype wire

// File: hdl/vgd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vgd_ctrl
// Sequencer: loads points, walks each stored point through the divider,
// distance pipeline and cell search, then emits one item per cell.
// ----------------------------------------------------------------------------
module vgd_ctrl import vgd_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic                i_last,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    input  wire t_dp_status          i_status,
    output t_dp_cmd                  o_cmd
);

    t_state              r_state, n_state;
    logic [PtCntW-1:0]   r_pt_cnt, n_pt_cnt;
    logic [PtIdxW-1:0]   r_n, n_n;
    logic [CellCntW-1:0] r_cell_cnt, n_cell_cnt;
    logic [CellIdxW-1:0] r_c, n_c;
    logic [LevelW-1:0]   r_step, n_step;
    logic                r_keep;
    logic [LevelW-1:0]   r_level;
    logic [LevelW-1:0]   lvl;
    logic                accept, full, last_pt, last_cell;

    assign lvl       = (r_level > LevelW'(MaxLevel)) ? LevelW'(MaxLevel) : r_level;
    assign accept    = i_in_valid && (r_state == ST_LOAD);
    assign full      = (r_pt_cnt == PtCntW'(MaxPoints));
    assign last_pt   = (PtCntW'(r_n) + PtCntW'(1) == r_pt_cnt);
    assign last_cell = (CellCntW'(r_c) + CellCntW'(1) == r_cell_cnt);
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep  <= 1'b0;
            r_level <= LevelReset;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_KEEP_MODE) r_keep <= i_cfg_data[0];
            if (i_cfg_index == CFG_GRID_LEVEL) r_level <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_pt_cnt   <= '0;
            r_n        <= '0;
            r_cell_cnt <= '0;
            r_c        <= '0;
            r_step     <= '0;
        end else begin
            r_state    <= n_state;
            r_pt_cnt   <= n_pt_cnt;
            r_n        <= n_n;
            r_cell_cnt <= n_cell_cnt;
            r_c        <= n_c;
            r_step     <= n_step;
        end
    end

    // next state and counters
    always_comb begin
        n_state    = r_state;
        n_pt_cnt   = r_pt_cnt;
        n_n        = r_n;
        n_cell_cnt = r_cell_cnt;
        n_c        = r_c;
        n_step     = r_step;
        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    if (!full) n_pt_cnt = r_pt_cnt + PtCntW'(1);
                    if (i_last) begin
                        n_n     = '0;
                        n_state = ST_PT_RD;
                    end
                end
            end
            ST_PT_RD:    n_state = ST_DIV_INIT;
            ST_DIV_INIT: begin
                n_step  = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_step == lvl) begin
                    n_state = ST_MUL;
                end else begin
                    n_step = r_step + LevelW'(1);
                end
            end
            ST_MUL: n_state = ST_ABS;
            ST_ABS: n_state = ST_SQ;
            ST_SQ:  n_state = ST_SUM;
            ST_SUM: begin
                n_c     = '0;
                n_state = (r_cell_cnt == '0) ? ST_APPEND : ST_CELL_RD;
            end
            ST_CELL_RD: n_state = ST_CELL_CMP;
            ST_CELL_CMP, ST_APPEND: begin
                if (r_state == ST_CELL_CMP && !i_status.match && !last_cell) begin
                    n_c     = r_c + CellIdxW'(1);
                    n_state = ST_CELL_RD;
                end else if (r_state == ST_CELL_CMP && !i_status.match) begin
                    n_state = ST_APPEND;
                end else begin
                    if (r_state == ST_APPEND && r_cell_cnt != CellCntW'(MaxCells)) begin
                        n_cell_cnt = r_cell_cnt + CellCntW'(1);
                    end
                    // advance to the next stored point or start emitting
                    if (last_pt) begin
                        n_c     = '0;
                        n_state = ST_EMIT_RD;
                    end else begin
                        n_n     = r_n + PtIdxW'(1);
                        n_state = ST_PT_RD;
                    end
                end
            end
            ST_EMIT_RD: n_state = (r_cell_cnt == '0) ? ST_CLEAR : ST_EMIT_LD;
            ST_EMIT_LD: n_state = ST_EMIT_OUT;
            ST_EMIT_OUT: begin
                if (i_status.out_taken) begin
                    if (last_cell) begin
                        n_state = ST_CLEAR;
                    end else begin
                        n_c     = r_c + CellIdxW'(1);
                        n_state = ST_EMIT_RD;
                    end
                end
            end
            ST_CLEAR: begin
                n_pt_cnt   = '0;
                n_cell_cnt = '0;
                n_state    = ST_LOAD;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.level     = lvl;
        o_cmd.pt_addr   = (r_state == ST_LOAD) ? r_pt_cnt[PtIdxW-1:0] : r_n;
        o_cmd.cell_addr = (r_state == ST_APPEND) ? r_cell_cnt[CellIdxW-1:0] : r_c;
        case (r_state)
            ST_LOAD: begin
                o_cmd.load_pt   = accept && !full;
                o_cmd.set_pdrop = accept && full;
            end
            ST_PT_RD:    o_cmd.pt_rd    = 1'b1;
            ST_DIV_INIT: o_cmd.div_init = 1'b1;
            ST_DIV:      o_cmd.div_step = (r_step != lvl);
            ST_MUL:      o_cmd.mul      = 1'b1;
            ST_ABS:      o_cmd.absd     = 1'b1;
            ST_SQ:       o_cmd.sq       = 1'b1;
            ST_SUM:      o_cmd.sum      = 1'b1;
            ST_CELL_RD:  o_cmd.cell_rd  = 1'b1;
            ST_CELL_CMP: o_cmd.cell_upd = i_status.match && r_keep && i_status.better;
            ST_APPEND: begin
                o_cmd.cell_new  = (r_cell_cnt != CellCntW'(MaxCells));
                o_cmd.set_vdrop = (r_cell_cnt == CellCntW'(MaxCells));
            end
            ST_EMIT_RD:  o_cmd.cell_rd = 1'b1;
            ST_EMIT_LD: begin
                o_cmd.out_load  = 1'b1;
                o_cmd.out_final = last_cell;
            end
            ST_EMIT_OUT: ;
            ST_CLEAR:    o_cmd.clear = 1'b1;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/voxel_grid_downsampler_unit.sv
`default_nettype none
// Loading: one cycle per point item, ready while in the load state.
// After the last point: per stored point a point read, divider init, divider steps
// (level clamped to 16), multiply, abs difference, square, sum, then a cell table
// search (read and compare per entry, append when not found); then per cell a read,
// load and output wait, then clearing; the sequencer handles one cloud at a time.
// Reset: synchronous; no clearing pass, the cloud state is cleared after emit.
// ----------------------------------------------------------------------------
// voxel_grid_downsampler_unit
// Voxel grid downsampler: stores a cloud and emits one point index per voxel.
// ----------------------------------------------------------------------------
module voxel_grid_downsampler_unit import vgd_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire t_point_in           i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output t_result_out              o_out_data,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [CfgDataW-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    vgd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_last      (i_in_data.last_point),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    vgd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_point     (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
